FILE: rtl/core/rshe_pkg.sv
package rshe_pkg;

  localparam int MAX_DEGREE_DEF    = 8;
  localparam int ANGLE_BITS_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 18;

  // Number of series terms beyond the first in the sine and cosine expansions.
  localparam logic [3:0] TAYLOR_TERMS = 4'd8;

  localparam logic signed [63:0] PI_Q60  = 64'sh3243_F6A8_885A_308D;
  localparam logic signed [63:0] ONE_Q60 = 64'sh1000_0000_0000_0000;
  localparam logic [63:0] TWO_OVER_PI_Q56 = 64'h00A2_F983_6E4E_4415;

  localparam logic signed [63:0] VALUE_MAX = 64'sd524287;
  localparam logic signed [63:0] VALUE_MIN = -64'sd524288;

  localparam int VALUE_W = 20;
  localparam int COEF_W  = 32;
  localparam int SHIFT_W = 7;
  localparam int DEN_W   = 9;

  // Divisor of the k-th sine series term: (2k)(2k+1).
  function automatic logic [DEN_W-1:0] sin_den(input logic [3:0] k);
    logic [DEN_W-1:0] t;
    t = {4'b0, k, 1'b0};
    return t * (t + 9'd1);
  endfunction

  // Divisor of the k-th cosine series term: (2k-1)(2k).
  function automatic logic [DEN_W-1:0] cos_den(input logic [3:0] k);
    logic [DEN_W-1:0] t;
    t = {4'b0, k, 1'b0};
    return t * (t - 9'd1);
  endfunction

  // Binomial coefficient from a Pascal row.
  function automatic longint binom(input int n, input int k);
    longint row [0:16];
    for (int c = 0; c <= 16; c++) begin
      row[c] = 0;
    end
    row[0] = 1;
    for (int r = 1; r <= n; r++) begin
      for (int c = 16; c >= 1; c--) begin
        row[c] = row[c] + row[c-1];
      end
    end
    return row[k];
  endfunction

  // Coefficient of x^d of the |m|-th derivative of the degree-l polynomial.
  function automatic logic signed [COEF_W-1:0] coef_value(input int l, input int am,
                                                         input int d);
    int     j;
    int     k;
    longint a;
    j = d + am;
    a = 0;
    if (((l - j) & 1) == 0) begin
      k = (l - j) >> 1;
      a = binom(l, k) * binom(2 * l - 2 * k, l);
      for (int i = 0; i < am; i++) begin
        a = a * longint'(j - i);
      end
      if ((k & 1) != 0) begin
        a = -a;
      end
    end
    return COEF_W'(a);
  endfunction

  // Start of the coefficient run for (l, am) in the flattened table.
  function automatic int coef_base(input int l, input int am);
    int b;
    b = 0;
    for (int lp = 0; lp < l; lp++) begin
      b = b + (((lp + 1) * (lp + 2)) >> 1);
    end
    for (int a = 0; a < am; a++) begin
      b = b + (l - a + 1);
    end
    return b;
  endfunction

  // Normalized quotient of the squared norm and its exponent, packed {e, q}.
  function automatic logic [71:0] norm_pair(input int l, input int am);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    logic [63:0] rem;
    int          e;
    num = TWO_OVER_PI_Q56 * 64'((2 * l + 1) * ((l == 1 && am != 0) ? 2 : 1));
    den = 64'd1;
    for (int i = l - am + 1; i <= l + am; i++) begin
      den = den * 64'(i);
    end
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem  = rem - den;
        q[b] = 1'b1;
      end
    end
    e = 0;
    while ((q < (64'd1 << 60) || ((e + 59) & 1) != 0) && e < 120) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= den) begin
        rem  = rem - den;
        q[0] = 1'b1;
      end
      e++;
    end
    return {8'(e), q};
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v    = v_in;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) begin
      bitv = bitv >> 2;
    end
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] norm_root(input int l, input int am);
    logic [71:0] pr;
    logic [63:0] r;
    pr = norm_pair(l, am);
    r  = isqrt64(pr[63:0]);
    return r[31:0];
  endfunction

  // Final right shift: Q30 product, norm exponent, 2^-l, down to the output scale.
  function automatic logic [SHIFT_W-1:0] norm_shift(input int l, input int am,
                                                    input int fb);
    logic [71:0] pr;
    int          e;
    pr = norm_pair(l, am);
    e  = int'(pr[71:64]);
    return SHIFT_W'(30 + ((e + 59) >> 1) + l - fb);
  endfunction

endpackage

FILE: rtl/core/real_spherical_harmonic_eval_core.sv
// Time from acceptance to a valid result grows with degree and |order|; an item with a
// rejected index pair skips the computation and goes straight to the saturation step.
// Items are taken one at a time, once the sequencer is back in idle after the previous
// result loads; the pace is set by the shared 32x32 multiplier and the 8-bit-per-cycle
// divider of the series terms.
// Reset: synchronous active-low rst_n idles the sequencer, drops out_valid, stalls input.
module real_spherical_harmonic_eval_core import rshe_pkg::*; #(
  parameter int MAX_DEGREE    = MAX_DEGREE_DEF,
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [ANGLE_BITS-1:0]     in_theta_angle,
  input  logic [ANGLE_BITS-1:0]     in_phi_angle,
  input  logic [3:0]                in_degree,
  input  logic signed [4:0]         in_order,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] out_harmonic_value,
  output logic                      out_bad_index
);

  // Tables indexed by degree and absolute order. They are elaborated from the
  // closed forms: the polynomial coefficients are packed one run per index pair,
  // and the norm is kept as a 31-bit root plus the right shift that goes with it.
  localparam int DEG_W  = (MAX_DEGREE > 0) ? $clog2(MAX_DEGREE + 1) : 1;
  localparam int COEF_N = (MAX_DEGREE + 1) * (MAX_DEGREE + 2) * (MAX_DEGREE + 3) / 6;
  localparam int CIDX_W = (COEF_N > 1) ? $clog2(COEF_N) : 1;

  logic signed [COEF_W-1:0]  coef_tab [0:COEF_N-1];
  logic [CIDX_W-1:0]         base_tab [0:MAX_DEGREE][0:MAX_DEGREE];
  logic [31:0]               root_tab [0:MAX_DEGREE][0:MAX_DEGREE];
  logic [SHIFT_W-1:0]        nsh_tab  [0:MAX_DEGREE][0:MAX_DEGREE];

  for (genvar gl = 0; gl <= MAX_DEGREE; gl++) begin : g_deg
    for (genvar ga = 0; ga <= MAX_DEGREE; ga++) begin : g_ord
      if (ga <= gl) begin : g_valid
        assign base_tab[gl][ga] = CIDX_W'(coef_base(gl, ga));
        assign root_tab[gl][ga] = norm_root(gl, ga);
        assign nsh_tab[gl][ga]  = norm_shift(gl, ga, FRACTION_BITS);
        for (genvar gd = 0; gd <= gl - ga; gd++) begin : g_coef
          assign coef_tab[coef_base(gl, ga) + gd] = coef_value(gl, ga, gd);
        end
      end else begin : g_unused
        assign base_tab[gl][ga] = '0;
        assign root_tab[gl][ga] = '0;
        assign nsh_tab[gl][ga]  = '0;
      end
    end
  end

  // The sequencer. Every product of the series and the polynomial goes through one
  // shared unit: the magnitudes are split into 32-bit halves, four partial products
  // are summed into a 128-bit accumulator in the S_MUL steps, and an S_MRND step
  // rounds half away from zero, shifts and restores the sign. The series divisors are
  // at most nine bits, so the divider retires eight quotient bits a cycle. Caller states
  // name the state that takes the result, and both units return there with it in res_r.
  typedef enum logic [4:0] {
    S_IDLE,
    S_MUL,
    S_MRND,
    S_DIV,
    T_INIT,
    T_X,
    T_X2,
    T_SDIV,
    T_SACC,
    T_CDIV,
    T_CACC,
    T_RC,
    T_FIN,
    H_ADD,
    P_LOOP,
    P_RET,
    P_NORM,
    S_SAT
  } state_t;

  state_t                    state_r, state_nxt;
  state_t                    ret_r, ret_nxt;
  logic [1:0]                mcnt_r, mcnt_nxt;
  logic [2:0]                dcnt_r, dcnt_nxt;
  logic [3:0]                cnt_r, cnt_nxt;
  logic                      which_r, which_nxt;
  logic [1:0]                quad_r, quad_nxt;
  logic                      swap_r, swap_nxt;
  logic [ANGLE_BITS-1:0]     ang_r, ang_nxt;
  logic [ANGLE_BITS-1:0]     phi_arg_r, phi_arg_nxt;
  logic [3:0]                l_r, l_nxt;
  logic [3:0]                am_r, am_nxt;
  logic                      mneg_r, mneg_nxt;
  logic                      bad_r, bad_nxt;
  logic [63:0]               mul_ua_r, mul_ua_nxt;
  logic [63:0]               mul_ub_r, mul_ub_nxt;
  logic                      mul_neg_r, mul_neg_nxt;
  logic [SHIFT_W-1:0]        mul_sh_r, mul_sh_nxt;
  logic [127:0]              mprod_r, mprod_nxt;
  logic [63:0]               div_n_r, div_n_nxt;
  logic [63:0]               div_q_r, div_q_nxt;
  logic [DEN_W-1:0]          div_rem_r, div_rem_nxt;
  logic [DEN_W-1:0]          div_den_r, div_den_nxt;
  logic                      div_neg_r, div_neg_nxt;
  logic signed [63:0]        res_r, res_nxt;
  logic signed [63:0]        x_r, x_nxt;
  logic signed [63:0]        x2_r, x2_nxt;
  logic signed [63:0]        ts_r, ts_nxt;
  logic signed [63:0]        tc_r, tc_nxt;
  logic signed [63:0]        ss_r, ss_nxt;
  logic signed [63:0]        cc_r, cc_nxt;
  logic signed [31:0]        st_r, st_nxt;
  logic signed [31:0]        ct_r, ct_nxt;
  logic signed [31:0]        trig_r, trig_nxt;
  logic signed [63:0]        acc_r, acc_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic                      out_bad_r, out_bad_nxt;

  // Requests to the shared units from the caller states.
  logic                      ms_go;
  logic signed [63:0]        ms_a;
  logic signed [63:0]        ms_b;
  logic [SHIFT_W-1:0]        ms_sh;
  state_t                    ms_ret;
  logic                      ds_go;
  logic [DEN_W-1:0]          ds_den;
  state_t                    ds_ret;

  // Working values.
  logic [4:0]                am5;
  logic [31:0]               a_half;
  logic [31:0]               b_half;
  logic [63:0]               pp;
  logic [127:0]              rnd;
  logic [127:0]              shifted;
  logic [DEN_W:0]            r10;
  logic [DEN_W-1:0]          rem9;
  logic [7:0]                qb;
  logic [63:0]               qfinal;
  logic [31:0]               turn;
  logic [29:0]               fpart;
  logic [29:0]               fred;
  logic                      swap_c;
  logic signed [31:0]        s0;
  logic signed [31:0]        c0;
  logic signed [31:0]        sv;
  logic signed [31:0]        cv;
  logic [CIDX_W-1:0]         coef_idx;
  logic signed [COEF_W-1:0]  coef_cur;
  logic signed [63:0]        acc_new;

  assign coef_idx = base_tab[l_r[DEG_W-1:0]][am_r[DEG_W-1:0]] + CIDX_W'(cnt_r);
  assign coef_cur = coef_tab[coef_idx];

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    mcnt_nxt      = mcnt_r;
    dcnt_nxt      = dcnt_r;
    cnt_nxt       = cnt_r;
    which_nxt     = which_r;
    quad_nxt      = quad_r;
    swap_nxt      = swap_r;
    ang_nxt       = ang_r;
    phi_arg_nxt   = phi_arg_r;
    l_nxt         = l_r;
    am_nxt        = am_r;
    mneg_nxt      = mneg_r;
    bad_nxt       = bad_r;
    mul_ua_nxt    = mul_ua_r;
    mul_ub_nxt    = mul_ub_r;
    mul_neg_nxt   = mul_neg_r;
    mul_sh_nxt    = mul_sh_r;
    mprod_nxt     = mprod_r;
    div_n_nxt     = div_n_r;
    div_q_nxt     = div_q_r;
    div_rem_nxt   = div_rem_r;
    div_den_nxt   = div_den_r;
    div_neg_nxt   = div_neg_r;
    res_nxt       = res_r;
    x_nxt         = x_r;
    x2_nxt        = x2_r;
    ts_nxt        = ts_r;
    tc_nxt        = tc_r;
    ss_nxt        = ss_r;
    cc_nxt        = cc_r;
    st_nxt        = st_r;
    ct_nxt        = ct_r;
    trig_nxt      = trig_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_bad_nxt   = out_bad_r;

    ms_go   = 1'b0;
    ms_a    = '0;
    ms_b    = '0;
    ms_sh   = '0;
    ms_ret  = S_IDLE;
    ds_go   = 1'b0;
    ds_den  = '0;
    ds_ret  = S_IDLE;

    am5     = in_order[4] ? 5'(-in_order) : 5'(in_order);
    a_half  = mcnt_r[1] ? mul_ua_r[63:32] : mul_ua_r[31:0];
    b_half  = mcnt_r[0] ? mul_ub_r[63:32] : mul_ub_r[31:0];
    pp      = a_half * b_half;
    rnd     = mprod_r + (128'd1 << (mul_sh_r - 7'd1));
    shifted = rnd >> mul_sh_r;
    r10     = '0;
    rem9    = div_rem_r;
    qb      = '0;
    qfinal  = '0;
    turn    = {ang_r, {(32 - ANGLE_BITS){1'b0}}};
    fpart   = turn[29:0];
    swap_c  = fpart > 30'h2000_0000;
    fred    = swap_c ? (30'h2000_0000 - fpart + 30'h2000_0000) : fpart;
    s0      = swap_r ? res_r[31:0] : ss_r[31:0];
    c0      = swap_r ? ss_r[31:0] : res_r[31:0];
    sv      = s0;
    cv      = c0;
    acc_new = res_r + {{2{coef_cur[COEF_W-1]}}, coef_cur, 30'b0};

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          l_nxt    = in_degree;
          am_nxt   = am5[3:0];
          mneg_nxt = in_order[4];
          if ((in_degree > 4'(MAX_DEGREE)) || (am5 > {1'b0, in_degree})) begin
            bad_nxt   = 1'b1;
            res_nxt   = '0;
            state_nxt = S_SAT;
          end else begin
            bad_nxt     = 1'b0;
            ang_nxt     = in_theta_angle;
            phi_arg_nxt = in_phi_angle * {{(ANGLE_BITS - 4){1'b0}}, am5[3:0]};
            which_nxt   = 1'b0;
            state_nxt   = T_INIT;
          end
        end
      end

      S_MUL: begin
        case (mcnt_r)
          2'd0:    mprod_nxt = mprod_r + 128'(pp);
          2'd3:    mprod_nxt = mprod_r + (128'(pp) << 64);
          default: mprod_nxt = mprod_r + (128'(pp) << 32);
        endcase
        mcnt_nxt = mcnt_r + 2'd1;
        if (mcnt_r == 2'd3) begin
          state_nxt = S_MRND;
        end
      end

      S_MRND: begin
        res_nxt   = mul_neg_r ? -$signed(shifted[63:0]) : $signed(shifted[63:0]);
        state_nxt = ret_r;
      end

      S_DIV: begin
        for (int b = 0; b < 8; b++) begin
          r10 = {rem9, div_n_r[63 - b]};
          if (r10 >= {1'b0, div_den_r}) begin
            r10       = r10 - {1'b0, div_den_r};
            qb[7 - b] = 1'b1;
          end
          rem9 = r10[DEN_W-1:0];
        end
        qfinal      = {div_q_r[55:0], qb};
        div_q_nxt   = qfinal;
        div_n_nxt   = div_n_r << 8;
        div_rem_nxt = rem9;
        dcnt_nxt    = dcnt_r + 3'd1;
        if (dcnt_r == 3'd7) begin
          // The series term is the negated truncated quotient.
          res_nxt   = div_neg_r ? $signed(qfinal) : -$signed(qfinal);
          state_nxt = ret_r;
        end
      end

      T_INIT: begin
        quad_nxt = turn[31:30];
        swap_nxt = swap_c;
        ms_go    = 1'b1;
        ms_a     = {34'b0, fred};
        ms_b     = PI_Q60;
        ms_sh    = 7'd31;
        ms_ret   = T_X;
      end

      T_X: begin
        x_nxt  = res_r;
        ms_go  = 1'b1;
        ms_a   = res_r;
        ms_b   = res_r;
        ms_sh  = 7'd60;
        ms_ret = T_X2;
      end

      T_X2: begin
        x2_nxt  = res_r;
        ts_nxt  = x_r;
        ss_nxt  = x_r;
        tc_nxt  = ONE_Q60;
        cc_nxt  = ONE_Q60;
        cnt_nxt = 4'd1;
        ms_go   = 1'b1;
        ms_a    = x_r;
        ms_b    = res_r;
        ms_sh   = 7'd60;
        ms_ret  = T_SDIV;
      end

      T_SDIV: begin
        ds_go  = 1'b1;
        ds_den = sin_den(cnt_r);
        ds_ret = T_SACC;
      end

      T_SACC: begin
        ts_nxt = res_r;
        ss_nxt = ss_r + res_r;
        ms_go  = 1'b1;
        ms_a   = tc_r;
        ms_b   = x2_r;
        ms_sh  = 7'd60;
        ms_ret = T_CDIV;
      end

      T_CDIV: begin
        ds_go  = 1'b1;
        ds_den = cos_den(cnt_r);
        ds_ret = T_CACC;
      end

      T_CACC: begin
        tc_nxt = res_r;
        cc_nxt = cc_r + res_r;
        ms_go  = 1'b1;
        if (cnt_r == TAYLOR_TERMS) begin
          ms_a   = ss_r;
          ms_b   = 64'sd1;
          ms_sh  = 7'd30;
          ms_ret = T_RC;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
          ms_a    = ts_r;
          ms_b    = x2_r;
          ms_sh   = 7'd60;
          ms_ret  = T_SDIV;
        end
      end

      T_RC: begin
        ss_nxt = res_r;
        ms_go  = 1'b1;
        ms_a   = cc_r;
        ms_b   = 64'sd1;
        ms_sh  = 7'd30;
        ms_ret = T_FIN;
      end

      T_FIN: begin
        case (quad_r)
          2'd0: begin
            sv = s0;
            cv = c0;
          end
          2'd1: begin
            sv = c0;
            cv = -s0;
          end
          2'd2: begin
            sv = -s0;
            cv = -c0;
          end
          default: begin
            sv = -c0;
            cv = s0;
          end
        endcase
        if (!which_r) begin
          st_nxt    = sv;
          ct_nxt    = cv;
          ang_nxt   = phi_arg_r;
          which_nxt = 1'b1;
          state_nxt = T_INIT;
        end else begin
          trig_nxt  = mneg_r ? sv : cv;
          res_nxt   = '0;
          cnt_nxt   = l_r - am_r;
          state_nxt = H_ADD;
        end
      end

      H_ADD: begin
        if (cnt_r == 4'd0) begin
          acc_nxt   = acc_new;
          cnt_nxt   = am_r;
          state_nxt = P_LOOP;
        end else begin
          cnt_nxt = cnt_r - 4'd1;
          ms_go   = 1'b1;
          ms_a    = acc_new;
          ms_b    = 64'(ct_r);
          ms_sh   = 7'd30;
          ms_ret  = H_ADD;
        end
      end

      P_LOOP: begin
        ms_go = 1'b1;
        ms_a  = acc_r;
        ms_sh = 7'd30;
        if (cnt_r != 4'd0) begin
          ms_b   = 64'(st_r);
          ms_ret = P_RET;
        end else begin
          ms_b   = 64'(trig_r);
          ms_ret = P_NORM;
        end
      end

      P_RET: begin
        acc_nxt   = res_r;
        cnt_nxt   = cnt_r - 4'd1;
        state_nxt = P_LOOP;
      end

      P_NORM: begin
        ms_go  = 1'b1;
        ms_a   = res_r;
        ms_b   = {32'b0, root_tab[l_r[DEG_W-1:0]][am_r[DEG_W-1:0]]};
        ms_sh  = nsh_tab[l_r[DEG_W-1:0]][am_r[DEG_W-1:0]];
        ms_ret = S_SAT;
      end

      S_SAT: begin
        if (!out_valid_r || !out_stall) begin
          if (res_r > VALUE_MAX) begin
            out_value_nxt = VALUE_MAX[VALUE_W-1:0];
          end else if (res_r < VALUE_MIN) begin
            out_value_nxt = VALUE_MIN[VALUE_W-1:0];
          end else begin
            out_value_nxt = res_r[VALUE_W-1:0];
          end
          out_bad_nxt   = bad_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (ms_go) begin
      mul_ua_nxt  = ms_a[63] ? (~ms_a + 64'd1) : ms_a;
      mul_ub_nxt  = ms_b[63] ? (~ms_b + 64'd1) : ms_b;
      mul_neg_nxt = ms_a[63] ^ ms_b[63];
      mul_sh_nxt  = ms_sh;
      mprod_nxt   = '0;
      mcnt_nxt    = 2'd0;
      ret_nxt     = ms_ret;
      state_nxt   = S_MUL;
    end

    if (ds_go) begin
      div_n_nxt   = res_r[63] ? (~res_r + 64'd1) : res_r;
      div_neg_nxt = res_r[63];
      div_den_nxt = ds_den;
      div_q_nxt   = '0;
      div_rem_nxt = '0;
      dcnt_nxt    = 3'd0;
      ret_nxt     = ds_ret;
      state_nxt   = S_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      mcnt_r      <= '0;
      dcnt_r      <= '0;
      cnt_r       <= '0;
      which_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      mcnt_r      <= mcnt_nxt;
      dcnt_r      <= dcnt_nxt;
      cnt_r       <= cnt_nxt;
      which_r     <= which_nxt;
      out_valid_r <= out_valid_nxt;
    end
    quad_r      <= quad_nxt;
    swap_r      <= swap_nxt;
    ang_r       <= ang_nxt;
    phi_arg_r   <= phi_arg_nxt;
    l_r         <= l_nxt;
    am_r        <= am_nxt;
    mneg_r      <= mneg_nxt;
    bad_r       <= bad_nxt;
    mul_ua_r    <= mul_ua_nxt;
    mul_ub_r    <= mul_ub_nxt;
    mul_neg_r   <= mul_neg_nxt;
    mul_sh_r    <= mul_sh_nxt;
    mprod_r     <= mprod_nxt;
    div_n_r     <= div_n_nxt;
    div_q_r     <= div_q_nxt;
    div_rem_r   <= div_rem_nxt;
    div_den_r   <= div_den_nxt;
    div_neg_r   <= div_neg_nxt;
    res_r       <= res_nxt;
    x_r         <= x_nxt;
    x2_r        <= x2_nxt;
    ts_r        <= ts_nxt;
    tc_r        <= tc_nxt;
    ss_r        <= ss_nxt;
    cc_r        <= cc_nxt;
    st_r        <= st_nxt;
    ct_r        <= ct_nxt;
    trig_r      <= trig_nxt;
    acc_r       <= acc_nxt;
    out_value_r <= out_value_nxt;
    out_bad_r   <= out_bad_nxt;
  end

  // The block takes a new item only while the sequencer is idle and out of reset;
  // a finished result waits in the output register and does not hold up the next item.
  assign in_stall           = !rst_n || (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_harmonic_value = out_value_r;
  assign out_bad_index      = out_bad_r;

  // A rejected index pair always reports a zero value.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_index |-> out_harmonic_value == '0)
    else $error("rejected index pair with nonzero value");

  // A new result is only loaded from the saturation step.
  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_SAT))
    else $error("result loaded outside the saturation step");

  // The partial product counter is parked whenever the multiplier is not running.
  a_mcnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_MUL |-> mcnt_r == 2'd0)
    else $error("multiplier counter out of step");

  // The divider counter is parked whenever the divider is not running.
  a_dcnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_DIV |-> dcnt_r == 3'd0)
    else $error("divider counter out of step");

endmodule
